>>> hdl/escaped_frame_transmitter_macros.svh
// ----------------------------------------------------------------------------
// Escaped frame transmitter assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_TRANSMITTER_MACROS_SVH
`define ESCAPED_FRAME_TRANSMITTER_MACROS_SVH

// Same-cycle implication
`define EFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define EFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/eft_pkg.sv
// ----------------------------------------------------------------------------
// eft_pkg
// Types and constants shared by the escaped frame transmitter modules.
// ----------------------------------------------------------------------------
package eft_pkg;

	// Escape range and the bit cleared in an escaped byte
	localparam logic [7:0] ESC_LOW  = 8'hD8;
	localparam logic [7:0] ESC_HIGH = 8'hDF;
	localparam logic [7:0] ESC_FLIP = 8'h10;

	// Input action codes
	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_STOP   = 2'd1;
	localparam logic [1:0] REG_ESCAPE = 2'd2;

	// Configuration register reset values
	localparam logic [7:0] START_RST  = 8'd216;
	localparam logic [7:0] STOP_RST   = 8'd217;
	localparam logic [7:0] ESCAPE_RST = 8'd218;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// Framing byte values
	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] stop_byte;
		logic [7:0] escape_byte;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic       need_start;
		logic       need_esc;
		logic       is_end;
		logic [7:0] value;
	} cmd_t;

endpackage

>>> hdl/eft_front.sv
// ----------------------------------------------------------------------------
// eft_front
// Accepts input beats, tracks frame state and the running sum, and turns
// each beat into one command for the back end.
// ----------------------------------------------------------------------------
module eft_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  eft_pkg::in_item_t in_item,
	input  logic [7:0]        escape_byte,
	input  logic              cmd_full,
	output logic              full,
	output logic              cmd_push,
	output eft_pkg::cmd_t     cmd
);

	logic       frame_open_q;
	logic [7:0] running_sum_q;
	logic [7:0] sum_base;
	logic [7:0] raw_value;
	logic [7:0] esc_value;
	logic       in_range;

	assign full     = cmd_full;
	assign cmd_push = push & ~cmd_full;

	// Sum restarts when a frame opens
	assign sum_base  = frame_open_q ? running_sum_q : 8'd0;
	assign raw_value = (in_item.action == eft_pkg::ACT_END) ? sum_base : in_item.data_byte;
	assign in_range  = (raw_value >= eft_pkg::ESC_LOW) && (raw_value <= eft_pkg::ESC_HIGH);
	assign esc_value = raw_value & ~eft_pkg::ESC_FLIP;

	// Command build
	always_comb begin
		cmd.need_start = ~frame_open_q;
		cmd.need_esc   = in_range;
		cmd.is_end     = (in_item.action == eft_pkg::ACT_END);
		cmd.value      = in_range ? esc_value : raw_value;
	end

	// Frame state and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q  <= 1'b0;
			running_sum_q <= 8'd0;
		end else if (cmd_push) begin
			if (in_item.action == eft_pkg::ACT_END) begin
				frame_open_q  <= 1'b0;
				running_sum_q <= 8'd0;
			end else begin
				frame_open_q <= 1'b1;
				if (in_range)
					running_sum_q <= sum_base + escape_byte + esc_value;
				else
					running_sum_q <= sum_base + raw_value;
			end
		end
	end

endmodule

>>> hdl/eft_cmd_fifo.sv
// ----------------------------------------------------------------------------
// eft_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module eft_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  eft_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output eft_pkg::cmd_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	eft_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hdl/eft_back.sv
// ----------------------------------------------------------------------------
// eft_back
// Walks each command through the start, escape, value and stop phases that it
// needs and puts one byte per cycle into the output register when it is free.
// ----------------------------------------------------------------------------
`include "escaped_frame_transmitter_macros.svh"

module eft_back (
	input  logic               clk,
	input  logic               arst_n,
	input  eft_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	input  eft_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               empty,
	input  logic               pop,
	output eft_pkg::out_item_t out_item
);

	typedef enum logic [1:0] {
		PH_START,
		PH_ESC,
		PH_VAL,
		PH_STOP
	} phase_t;

	phase_t             step_q;
	phase_t             eff_ph;
	logic               last;
	logic               emit;
	logic [7:0]         byte_sel;
	logic               out_valid_q;
	eft_pkg::out_item_t out_item_q;

	// Skip phases the command does not need
	always_comb begin
		eff_ph = step_q;
		if (eff_ph == PH_START && !cmd.need_start)
			eff_ph = PH_ESC;
		if (eff_ph == PH_ESC && !cmd.need_esc)
			eff_ph = PH_VAL;
	end

	assign last    = (eff_ph == PH_STOP) || (eff_ph == PH_VAL && !cmd.is_end);
	assign emit    = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = emit && last;
	assign empty   = ~out_valid_q;
	assign out_item = out_item_q;

	// Byte for the current phase
	always_comb begin
		case (eff_ph)
			PH_START: byte_sel = cfg.start_byte;
			PH_ESC:   byte_sel = cfg.escape_byte;
			PH_VAL:   byte_sel = cmd.value;
			PH_STOP:  byte_sel = cfg.stop_byte;
			default:  byte_sel = cmd.value;
		endcase
	end

	// Phase sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= PH_START;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (emit) begin
				out_valid_q         <= 1'b1;
				step_q              <= last ? PH_START : phase_t'(eff_ph + 2'd1);
				out_item_q.out_byte <= byte_sel;
				out_item_q.run_last <= last;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`EFT_ASSERT_NOW(a_mid_cmd_head, step_q != PH_START, cmd_valid, "mid-command without a command")
	`EFT_ASSERT_NEXT(a_last_resets_phase, emit && last, step_q == PH_START, "phase not rewound")
	`EFT_ASSERT_NOW(a_stop_only_end, cmd_valid && eff_ph == PH_STOP, cmd.is_end, "stop on payload")

endmodule

>>> hdl/escaped_frame_transmitter.sv
// ----------------------------------------------------------------------------
// escaped_frame_transmitter
// Byte-stuffing frame transmitter with an additive checksum.
// ----------------------------------------------------------------------------
// Each input beat is classified on acceptance and queued as one command; the
// back end then sends one output byte per cycle: one byte for a plain payload
// byte, two for an escaped one, plus the start byte ahead of the first beat of
// a frame; an end beat sends the sum (one or two bytes) and the stop byte. An
// input beat thus gives one to four output bytes; the output side runs at one
// byte per cycle while pop is held. The command queue of CMD_DEPTH entries lets
// input beats be taken while earlier ones are still being sent; run_last marks
// the final byte of each input beat. The user must write framing bytes through
// cfg_we/cfg_idx/cfg_wdata while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module escaped_frame_transmitter #(
	parameter int CMD_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  eft_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output eft_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [7:0]         cfg_wdata
);

	eft_pkg::cfg_t cfg_q;
	eft_pkg::cmd_t push_cmd;
	eft_pkg::cmd_t head_cmd;
	logic          cmd_push;
	logic          cmd_full;
	logic          cmd_valid;
	logic          cmd_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= eft_pkg::START_RST;
			cfg_q.stop_byte   <= eft_pkg::STOP_RST;
			cfg_q.escape_byte <= eft_pkg::ESCAPE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				eft_pkg::REG_START:  cfg_q.start_byte  <= cfg_wdata;
				eft_pkg::REG_STOP:   cfg_q.stop_byte   <= cfg_wdata;
				eft_pkg::REG_ESCAPE: cfg_q.escape_byte <= cfg_wdata;
				default: ;
			endcase
		end
	end

	eft_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_item     (in_item),
		.escape_byte (cfg_q.escape_byte),
		.cmd_full    (cmd_full),
		.full        (full),
		.cmd_push    (cmd_push),
		.cmd         (push_cmd)
	);

	eft_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (push_cmd),
		.full     (cmd_full),
		.rd_en    (cmd_pop),
		.rd_valid (cmd_valid),
		.rd_data  (head_cmd)
	);

	eft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

>>> tb/eft_tb_pkg.sv
// ----------------------------------------------------------------------------
// eft_tb_pkg
// Frame tracker for the escaped frame transmitter bench: predicts the serial
// bytes each accepted beat produces and checks popped bytes against them.
// ----------------------------------------------------------------------------
package eft_tb_pkg;

	import eft_pkg::*;

	class eft_frame_tracker;
		cfg_t       framing;
		bit         frame_open;
		logic [7:0] running_sum;
		out_item_t  bytes_due[$];
		int         errors;
		int         bytes_checked;
		int         escapes_sent;
		int         frames_closed;

		function new();
			framing.start_byte  = START_RST;
			framing.stop_byte   = STOP_RST;
			framing.escape_byte = ESCAPE_RST;
			frame_open          = 1'b0;
			running_sum         = '0;
			errors              = 0;
			bytes_checked       = 0;
			escapes_sent        = 0;
			frames_closed       = 0;
		endfunction

		// Register write; unused indexes are ignored
		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_START: begin
					framing.start_byte = val;
				end
				REG_STOP: begin
					framing.stop_byte = val;
				end
				REG_ESCAPE: begin
					framing.escape_byte = val;
				end
				default: begin
				end
			endcase
		endfunction

		function void put_byte(logic [7:0] b);
			out_item_t ob;
			ob.out_byte = b;
			ob.run_last = 1'b0;
			bytes_due.push_back(ob);
		endfunction

		// Escape rule; optionally folds the sent bytes into the sum
		function void put_escaped(logic [7:0] b, bit add);
			logic [7:0] folded;
			if (b >= ESC_LOW && b <= ESC_HIGH) begin
				folded = b & ~ESC_FLIP;
				put_byte(framing.escape_byte);
				put_byte(folded);
				if (add) begin
					running_sum  = running_sum + framing.escape_byte + folded;
					escapes_sent++;
				end
			end else begin
				put_byte(b);
				if (add)
					running_sum = running_sum + b;
			end
		endfunction

		// Expected bytes for one accepted input beat
		function void note_beat(in_item_t beat);
			if (!frame_open) begin
				put_byte(framing.start_byte);
				frame_open  = 1'b1;
				running_sum = '0;
			end
			if (beat.action == ACT_DATA) begin
				put_escaped(beat.data_byte, 1'b1);
			end else begin
				put_escaped(running_sum, 1'b0);
				put_byte(framing.stop_byte);
				frame_open  = 1'b0;
				running_sum = '0;
				frames_closed++;
			end
			bytes_due[bytes_due.size() - 1].run_last = 1'b1;
		endfunction

		// Compare one popped byte with the oldest expected one
		function void check_byte(out_item_t got);
			out_item_t want;
			bytes_checked++;
			if (bytes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte, expected none, actual %02h/%0b",
					$time, got.out_byte, got.run_last);
				return;
			end
			want = bytes_due.pop_front();
			if (got.out_byte !== want.out_byte) begin
				errors++;
				$display("%0t: out_byte mismatch, expected %02h, actual %02h",
					$time, want.out_byte, got.out_byte);
			end
			if (got.run_last !== want.run_last) begin
				errors++;
				$display("%0t: run_last mismatch, expected %0b, actual %0b",
					$time, want.run_last, got.run_last);
			end
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction
	endclass

endpackage

>>> tb/tb_escaped_frame_transmitter.sv
// ----------------------------------------------------------------------------
// tb_escaped_frame_transmitter
// Self-checking bench for the escaped frame transmitter: directed corner
// frames, then random frames under several framing settings with random
// push/pop gaps; every popped byte is checked against the frame tracker.
// ----------------------------------------------------------------------------
module tb_escaped_frame_transmitter;

	timeunit 1ns;
	timeprecision 1ps;

	import eft_pkg::*;
	import eft_tb_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	in_item_t   in_item;
	logic       empty;
	logic       pop;
	out_item_t  out_item;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_wdata;

	eft_frame_tracker tracker;
	bit feeder_steady;
	bit drainer_steady;
	int beats_sent;
	int settings_used;
	int cycles;

	escaped_frame_transmitter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One input beat: optional gap, then hold push until accepted
	task automatic send_beat(input logic act, input logic [7:0] data);
		int gap;
		in_item_t beat;
		gap = feeder_steady ? 0 : $urandom_range(0, 19);
		beat.action    = act;
		beat.data_byte = data;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		in_item <= beat;
		do @(posedge clk); while (full);
		tracker.note_beat(beat);
		beats_sent++;
	endtask

	// Stop pushing until every expected byte has been popped
	task automatic drain_results();
		push <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	// New framing bytes, written only with the block idle
	task automatic write_framing(input logic [7:0] sb, input logic [7:0] pb,
		input logic [7:0] eb, input bit poke_unused);
		drain_results();
		write_reg(REG_START, sb);
		write_reg(REG_STOP, pb);
		write_reg(REG_ESCAPE, eb);
		if (poke_unused)
			write_reg(REG_UNUSED, 8'h55);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Payload biased toward the escape range and the framing values
	function automatic logic [7:0] pick_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return ESC_LOW + 8'($urandom_range(0, 7));
		if (r < 45) begin
			case ($urandom_range(0, 2))
				0: return tracker.framing.start_byte;
				1: return tracker.framing.stop_byte;
				default: return tracker.framing.escape_byte;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly whole frames, some stray payload beats and repeated ends
	task automatic random_frames(input int n_beats);
		int target;
		int len;
		int pick;
		target = beats_sent + n_beats;
		while (beats_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) :
					$urandom_range(0, 5);
				repeat (len) send_beat(ACT_DATA, pick_payload());
				send_beat(ACT_END, 8'($urandom_range(0, 255)));
			end else if (pick < 93) begin
				send_beat(ACT_DATA, pick_payload());
			end else begin
				send_beat(ACT_END, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Result side: random pop stalls, check each popped byte
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = drainer_steady ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			tracker.check_byte(out_item);
		end
	end

	// Main sequence
	initial begin
		logic [7:0] corner_bytes [7] = '{8'h00, 8'hFF, 8'hD8, 8'hDF, 8'hD7, 8'hE0, 8'hDA};
		arst_n    <= 1'b0;
		push      <= 1'b0;
		pop       <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_START;
		cfg_wdata <= '0;
		cycles    <= 0;
		tracker   = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// End with no open frame gives an empty frame
		send_beat(ACT_END, 8'hFF);
		// Range edges, escape byte value inside the range
		foreach (corner_bytes[i])
			send_beat(ACT_DATA, corner_bytes[i]);
		send_beat(ACT_END, 8'h00);
		// Sum lands on 0xDC and gets escaped
		send_beat(ACT_DATA, 8'h6C);
		send_beat(ACT_DATA, 8'h70);
		send_beat(ACT_END, 8'hA5);

		// Framing values outside the escape range go out plain
		write_framing(8'h7E, 8'h7D, 8'h7D, 1'b1);
		send_beat(ACT_DATA, 8'h7E);
		send_beat(ACT_DATA, 8'h7D);
		send_beat(ACT_DATA, 8'hD9);
		send_beat(ACT_END, 8'h5A);
		send_beat(ACT_END, 8'h3C);

		// Random phases with extreme and random framing bytes
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: write_framing(8'h00, 8'hFF, 8'h00, 1'b0);
				1: write_framing(8'hFF, 8'h00, 8'hFF, 1'b0);
				default: write_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0);
			endcase
			feeder_steady  = (p == 1 || p == 3);
			drainer_steady = (p == 2 || p == 3);
			if (p == 0) begin
				// Sender holds off mid-frame until the line is idle
				send_beat(ACT_DATA, pick_payload());
				send_beat(ACT_DATA, pick_payload());
				drain_results();
				send_beat(ACT_END, 8'($urandom_range(0, 255)));
			end
			random_frames(40);
		end

		drain_results();
		$display("Sent %0d beats closing %0d frames under %0d framing settings;",
			beats_sent, tracker.frames_closed, settings_used + 1);
		$display("checked %0d serial bytes, %0d payload bytes were escaped.",
			tracker.bytes_checked, tracker.escapes_sent);
		if (tracker.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
